### rtl/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int HEAP_W  = 40;
  localparam int GRAN_W  = 21;
  localparam int ALIGN_W = 31;
  localparam int STAT_W  = 2;
  localparam int LIVE_W  = 7;
  localparam int FREE_W  = 41;

  localparam logic [HEAP_W-1:0] HEAP_RESET = 40'd268435456;
  localparam logic [GRAN_W-1:0] GRAN_RESET = 21'd1;
  localparam logic [FREE_W-1:0] FREE_RESET = 41'd268435456;
  localparam logic [FREE_W-1:0] FREE_MAX   = '1;
  localparam logic [HEAP_W-1:0] OUT_MAX    = '1;

  localparam logic CFG_HEAP_SIZE = 1'b0;
  localparam logic CFG_TYPE_GRAN = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FSCAN_RD,
    OP_FSCAN_NEXT,
    OP_FREE_HIT,
    OP_SD_RD,
    OP_SD_WR,
    OP_FREE_DONE,
    OP_FAIL_SPACE,
    OP_FAIL_FULL,
    OP_FAIL_NF,
    OP_EMPTY,
    OP_LAST_RD,
    OP_PE_LD,
    OP_BE,
    OP_G_RD0,
    OP_G_NEXT,
    OP_INS_START,
    OP_SU_RD,
    OP_SU_WR,
    OP_INS_DONE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ffra_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_ge2;
    logic size_ok;
    logic fscan_end;
    logic hit_ge;
    logic hit_eq;
    logic fit;
    logic pair_end;
    logic sd_end;
    logic su_end;
  } ffra_sts_t;

  // Round down to a power of two; zero counts as one.
  function automatic logic [ALIGN_W-1:0] pow2_floor(input logic [ALIGN_W-1:0] v);
    logic [ALIGN_W-1:0] p;
    p = ALIGN_W'(1);
    for (int k = 0; k < ALIGN_W; k++) begin
      if (v[k]) p = ALIGN_W'(1) << k;
    end
    return p;
  endfunction

endpackage

### rtl/ffra_dp.sv
`timescale 1ns / 1ps
module ffra_dp import ffra_pkg::*; #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [HEAP_W-1:0]    cfg_wdata,
  input  logic                 in_resource_kind,
  input  logic [HEAP_W-1:0]    in_request_bytes,
  input  logic [ALIGN_W-1:0]   in_align_bytes,
  input  logic [HEAP_W-1:0]    in_release_offset,
  input  ffra_cmd_t            cmd,
  output ffra_sts_t            sts,
  output logic [STAT_W-1:0]    out_status,
  output logic [HEAP_W-1:0]    out_chunk_offset,
  output logic [HEAP_W-1:0]    out_chunk_bytes,
  output logic [HEAP_W-1:0]    out_bytes_free,
  output logic [LIVE_W-1:0]    out_live_count
);

  localparam int AB = ADDR_BITS;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam int AW = ((AB > ALIGN_W) ? AB : ALIGN_W) + 2;
  localparam int FW = (AB > FREE_W) ? AB : FREE_W;
  localparam int SW = FW + 1;

  logic [AB-1:0] mem_start [MAX_RANGES];
  logic [AB-1:0] mem_len   [MAX_RANGES];
  logic          mem_kind  [MAX_RANGES];

  logic [HEAP_W-1:0]  heap_size_r;
  logic [GRAN_W-1:0]  gran_r;
  logic [FREE_W-1:0]  free_r;
  logic [CW-1:0]      count_r;

  logic [CW-1:0]      idx_r, j_r, p_r;
  logic               kind_r, size_ok_r, last_mode_r, pk_r, nk_r;
  logic [AB-1:0]      size_r, rel_r, lim_r, bytes_r;
  logic [ALIGN_W-1:0] align_r;
  logic [AW-1:0]      pe_r, npe_r, b_r, e_r, off_r;
  logic [AB-1:0]      rd_start_r, rd_len_r;
  logic               rd_kind_r;
  logic [STAT_W-1:0]  res_status_r;
  logic [AB-1:0]      res_off_r, res_bytes_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [HEAP_W-1:0]  out_off_r, out_bytes_r, out_free_r;
  logic [LIVE_W-1:0]  out_live_r;

  logic [AB-1:0]      hsize, in_size;
  logic [ALIGN_W-1:0] gran_p, wide;
  logic [AW-1:0]      ama, amw, am_b, am_e, b_calc, e_calc, rd_sum, gap;
  logic               pm, nm;
  logic [SW-1:0]      free_add;
  logic [FREE_W-1:0]  free_add_sat, free_sub;
  logic [CW:0]        j_p1, idx_p1, idx_p2, j_m1, cnt_m1;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [AB-1:0]      wr_start, wr_len;
  logic               wr_kind;

  assign hsize   = AB'(heap_size_r);
  assign in_size = AB'(in_request_bytes);
  assign gran_p  = pow2_floor(ALIGN_W'(gran_r));
  assign wide    = (align_r > gran_p) ? align_r : gran_p;
  assign ama     = AW'(align_r) - AW'(1);
  assign amw     = AW'(wide) - AW'(1);
  assign pm      = (pk_r != kind_r);
  assign nm      = (rd_kind_r != kind_r);
  assign am_b    = pm ? amw : ama;
  assign am_e    = nm ? amw : ama;
  assign b_calc  = (pe_r + am_b) & ~am_b;
  assign rd_sum  = AW'(rd_start_r) + AW'(rd_len_r);
  assign gap     = e_r - b_r;

  always_comb begin
    if (last_mode_r) begin
      e_calc = AW'(hsize);
    end else if (!pm && !nm) begin
      e_calc = AW'(rd_start_r);
    end else begin
      e_calc = AW'(rd_start_r) & ~am_e;
    end
  end

  assign free_add     = SW'(free_r) + SW'(bytes_r);
  assign free_add_sat = (free_add > SW'(FREE_MAX)) ? FREE_MAX : FREE_W'(free_add);
  assign free_sub     = (FW'(free_r) >= FW'(size_r)) ? FREE_W'(FW'(free_r) - FW'(size_r))
                                                     : '0;

  assign j_p1   = {1'b0, j_r} + (CW+1)'(1);
  assign j_m1   = {1'b0, j_r} - (CW+1)'(1);
  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);
  assign cnt_m1 = {1'b0, count_r} - (CW+1)'(1);

  always_comb begin
    sts.cnt_zero  = (count_r == '0);
    sts.cnt_full  = (count_r >= CW'(MAX_RANGES));
    sts.cnt_ge2   = (count_r >= CW'(2));
    sts.size_ok   = size_ok_r;
    sts.fscan_end = (idx_r >= count_r);
    sts.hit_ge    = (rd_start_r >= rel_r);
    sts.hit_eq    = (rd_start_r == rel_r);
    sts.fit       = (e_r >= b_r) && (gap >= AW'(size_r)) && size_ok_r &&
                    (b_r <= AW'(lim_r));
    sts.pair_end  = (idx_p2 >= {1'b0, count_r});
    sts.sd_end    = (j_p1 >= {1'b0, count_r});
    sts.su_end    = (j_r == p_r);
  end

  // Memory port selection.
  always_comb begin
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = j_r[IW-1:0];
    wr_start = rd_start_r;
    wr_len   = rd_len_r;
    wr_kind  = rd_kind_r;
    unique case (cmd.op)
      OP_FSCAN_RD: rd_addr = idx_r[IW-1:0];
      OP_SD_RD:    rd_addr = j_p1[IW-1:0];
      OP_LAST_RD:  rd_addr = cnt_m1[IW-1:0];
      OP_PE_LD:    rd_addr = idx_p1[IW-1:0];
      OP_G_NEXT:   rd_addr = idx_p2[IW-1:0];
      OP_SU_RD:    rd_addr = j_m1[IW-1:0];
      OP_SD_WR, OP_SU_WR: wr_en = 1'b1;
      OP_INS_DONE: begin
        wr_en    = 1'b1;
        wr_addr  = p_r[IW-1:0];
        wr_start = AB'(off_r);
        wr_len   = size_r;
        wr_kind  = kind_r;
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
      mem_kind[wr_addr]  <= wr_kind;
    end
    rd_start_r <= mem_start[rd_addr];
    rd_len_r   <= mem_len[rd_addr];
    rd_kind_r  <= mem_kind[rd_addr];
  end

  // Control state: configuration, counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_RESET;
      gran_r      <= GRAN_RESET;
      free_r      <= FREE_RESET;
      count_r     <= '0;
    end else begin
      if (cmd.op == OP_FREE_DONE) begin
        free_r  <= free_add_sat;
        count_r <= count_r - CW'(1);
      end else if (cmd.op == OP_INS_DONE) begin
        free_r  <= free_sub;
        count_r <= count_r + CW'(1);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_SIZE) begin
          heap_size_r <= cfg_wdata;
          if (count_r == '0) free_r <= FREE_W'(AB'(cfg_wdata));
        end else begin
          gran_r <= cfg_wdata[GRAN_W-1:0];
        end
      end
    end
  end

  // Working registers and results.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r    <= in_resource_kind;
        size_r    <= in_size;
        align_r   <= pow2_floor(in_align_bytes);
        rel_r     <= AB'(in_release_offset);
        lim_r     <= hsize - in_size;
        size_ok_r <= (in_size <= hsize);
        idx_r     <= '0;
      end
      OP_FSCAN_NEXT: idx_r <= idx_r + CW'(1);
      OP_FREE_HIT: begin
        bytes_r <= rd_len_r;
        j_r     <= idx_r;
      end
      OP_SD_WR: j_r <= j_r + CW'(1);
      OP_FREE_DONE: begin
        res_status_r <= ST_OK;
        res_off_r    <= '0;
        res_bytes_r  <= bytes_r;
      end
      OP_FAIL_SPACE, OP_FAIL_FULL, OP_FAIL_NF: begin
        res_status_r <= (cmd.op == OP_FAIL_SPACE) ? ST_NO_SPACE :
                        (cmd.op == OP_FAIL_FULL)  ? ST_FULL : ST_NOT_FOUND;
        res_off_r    <= '0;
        res_bytes_r  <= '0;
      end
      OP_EMPTY: begin
        off_r <= '0;
        p_r   <= '0;
        j_r   <= count_r;
      end
      OP_LAST_RD: last_mode_r <= 1'b1;
      OP_PE_LD: begin
        pe_r <= rd_sum;
        pk_r <= rd_kind_r;
      end
      OP_BE: begin
        b_r   <= b_calc;
        e_r   <= e_calc;
        npe_r <= rd_sum;
        nk_r  <= rd_kind_r;
      end
      OP_G_RD0: begin
        last_mode_r <= 1'b0;
        idx_r       <= '0;
      end
      OP_G_NEXT: begin
        pe_r  <= npe_r;
        pk_r  <= nk_r;
        idx_r <= idx_r + CW'(1);
      end
      OP_INS_START: begin
        p_r   <= last_mode_r ? count_r : CW'(idx_p1);
        j_r   <= count_r;
        off_r <= b_r;
      end
      OP_SU_WR: j_r <= j_r - CW'(1);
      OP_INS_DONE: begin
        res_status_r <= ST_OK;
        res_off_r    <= AB'(off_r);
        res_bytes_r  <= size_r;
      end
      OP_PUBLISH: begin
        out_status_r <= res_status_r;
        out_off_r    <= HEAP_W'(res_off_r);
        out_bytes_r  <= HEAP_W'(res_bytes_r);
        out_free_r   <= (free_r > FREE_W'(OUT_MAX)) ? OUT_MAX : HEAP_W'(free_r);
        out_live_r   <= LIVE_W'(count_r);
      end
      default: ;
    endcase
  end

  assign out_status       = out_status_r;
  assign out_chunk_offset = out_off_r;
  assign out_chunk_bytes  = out_bytes_r;
  assign out_bytes_free   = out_free_r;
  assign out_live_count   = out_live_r;

endmodule

### rtl/ffra_ctrl.sv
`timescale 1ns / 1ps
module ffra_ctrl import ffra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  input  logic      out_ready,
  input  ffra_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output ffra_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_START, S_A_LD, S_A_BE, S_A_CHK, S_G_LD0, S_G_BE, S_G_CHK,
    S_SU_CHK, S_SU_WR, S_F_RD, S_F_CHK, S_SD_CHK, S_SD_WR, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_cmd == CMD_FREE) ? S_F_RD : S_A_START;
        end
      end
      S_A_START: begin
        if (sts.cnt_full) begin
          cmd.op = OP_FAIL_FULL;
          state_nxt = S_FINISH;
        end else if (sts.cnt_zero) begin
          cmd.op    = sts.size_ok ? OP_EMPTY : OP_FAIL_SPACE;
          state_nxt = sts.size_ok ? S_SU_CHK : S_FINISH;
        end else begin
          cmd.op = OP_LAST_RD;
          state_nxt = S_A_LD;
        end
      end
      S_A_LD: begin
        cmd.op = OP_PE_LD;
        state_nxt = S_A_BE;
      end
      S_A_BE: begin
        cmd.op = OP_BE;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.fit) begin
          cmd.op = OP_INS_START;
          state_nxt = S_SU_CHK;
        end else if (sts.cnt_ge2) begin
          cmd.op = OP_G_RD0;
          state_nxt = S_G_LD0;
        end else begin
          cmd.op = OP_FAIL_SPACE;
          state_nxt = S_FINISH;
        end
      end
      S_G_LD0: begin
        cmd.op = OP_PE_LD;
        state_nxt = S_G_BE;
      end
      S_G_BE: begin
        cmd.op = OP_BE;
        state_nxt = S_G_CHK;
      end
      S_G_CHK: begin
        if (sts.fit) begin
          cmd.op = OP_INS_START;
          state_nxt = S_SU_CHK;
        end else if (sts.pair_end) begin
          cmd.op = OP_FAIL_SPACE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_G_NEXT;
          state_nxt = S_G_BE;
        end
      end
      S_SU_CHK: begin
        if (sts.su_end) begin
          cmd.op = OP_INS_DONE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_SU_RD;
          state_nxt = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.op = OP_SU_WR;
        state_nxt = S_SU_CHK;
      end
      S_F_RD: begin
        if (sts.fscan_end) begin
          cmd.op = OP_FAIL_NF;
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_FSCAN_RD;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts.hit_ge) begin
          cmd.op    = sts.hit_eq ? OP_FREE_HIT : OP_FAIL_NF;
          state_nxt = sts.hit_eq ? S_SD_CHK : S_FINISH;
        end else begin
          cmd.op = OP_FSCAN_NEXT;
          state_nxt = S_F_RD;
        end
      end
      S_SD_CHK: begin
        if (sts.sd_end) begin
          cmd.op = OP_FREE_DONE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_SD_RD;
          state_nxt = S_SD_WR;
        end
      end
      S_SD_WR: begin
        cmd.op = OP_SD_WR;
        state_nxt = S_SD_CHK;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op = OP_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.op == OP_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in_      in_valid / in_ready  cmd, resource_kind, request_bytes, align_bytes,
//                               release_offset
// out_     out_valid/out_ready  status, chunk_offset, chunk_bytes, bytes_free,
//                               live_count
// cfg_     cfg_we (no wait)     cfg_index, cfg_wdata
//
// One transaction at a time. A free walks the table entry by entry up to the
// match, then moves each later entry down. An allocate checks the tail, then
// walks neighbor pairs, then moves later entries up; pairs walked plus entries
// moved never exceed the live count.
// Reset is synchronous: table empty, free space = reset heap size. The result
// waits in an output register, so a new transaction is taken while it stalls.
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [HEAP_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic                in_resource_kind,
  input  logic [HEAP_W-1:0]   in_request_bytes,
  input  logic [ALIGN_W-1:0]  in_align_bytes,
  input  logic [HEAP_W-1:0]   in_release_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [HEAP_W-1:0]   out_chunk_offset,
  output logic [HEAP_W-1:0]   out_chunk_bytes,
  output logic [HEAP_W-1:0]   out_bytes_free,
  output logic [LIVE_W-1:0]   out_live_count
);

  ffra_cmd_t cmd;
  ffra_sts_t sts;

  // Sequencer: decides the next table step from datapath status.
  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Range table, alignment arithmetic, counters and result registers.
  ffra_dp #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_resource_kind  (in_resource_kind),
    .in_request_bytes  (in_request_bytes),
    .in_align_bytes    (in_align_bytes),
    .in_release_offset (in_release_offset),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_chunk_offset  (out_chunk_offset),
    .out_chunk_bytes   (out_chunk_bytes),
    .out_bytes_free    (out_bytes_free),
    .out_live_count    (out_live_count)
  );

endmodule
